// ----- hdl/day_masked_earliest_time_table_core_macros.svh -----
// Assertion macros used by the checker file of the table core.
// No dependencies; include by bare file name.
`ifndef DAY_MASKED_EARLIEST_TIME_TABLE_CORE_MACROS_SVH
`define DAY_MASKED_EARLIEST_TIME_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define DMET_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DMET_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/dmet_pkg.sv -----
// Package of the day-masked earliest-time table core: widths, defaults,
// opcodes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package dmet_pkg;

	localparam int LOCATIONS_DEF = 1024;
	localparam int ENTRIES_DEF   = 8;
	localparam int DAYS_DEF      = 64;

	localparam int LOC_W       = 10;
	localparam int TIME_W      = 21;
	localparam int DAYS_W      = 64;
	localparam int S_TDATA_W   = 96;
	localparam int M_TDATA_W   = 72;

	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_CNT,
		ST_START,
		ST_EVAL,
		ST_FIN,
		ST_OUT
	} dmet_state_t;

	typedef struct packed {
		logic accept;
		logic sweep;
		logic start;
		logic eval;
		logic fin;
		logic out_load;
	} dmet_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic clear_op;
		logic loc_ok;
		logic walk_go;
		logic eval_more;
		logic out_free;
	} dmet_sts_t;

endpackage

// ----- hdl/dmet_ctrl.sv -----
// Controller of the table core: sequences clear sweep, row walk, final
// write and result hand-off. Depends on dmet_pkg.
`timescale 1ns / 1ps

module dmet_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  dmet_pkg::dmet_sts_t  sts,
	output dmet_pkg::dmet_cmd_t  cmd
);

	dmet_pkg::dmet_state_t state_q, state_d;
	logic                  reply_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmet_pkg::ST_SWEEP;
			reply_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				reply_q <= sts.clear_op;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dmet_pkg::ST_SWEEP: begin
				if (sts.sweep_last) begin
					state_d = reply_q ? dmet_pkg::ST_OUT : dmet_pkg::ST_IDLE;
				end
			end
			dmet_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (sts.clear_op) begin
						state_d = dmet_pkg::ST_SWEEP;
					end else if (!sts.loc_ok) begin
						state_d = dmet_pkg::ST_OUT;
					end else begin
						state_d = dmet_pkg::ST_CNT;
					end
				end
			end
			dmet_pkg::ST_CNT:   state_d = dmet_pkg::ST_START;
			dmet_pkg::ST_START: state_d = sts.walk_go ? dmet_pkg::ST_EVAL : dmet_pkg::ST_FIN;
			dmet_pkg::ST_EVAL:  state_d = sts.eval_more ? dmet_pkg::ST_EVAL : dmet_pkg::ST_FIN;
			dmet_pkg::ST_FIN:   state_d = dmet_pkg::ST_OUT;
			dmet_pkg::ST_OUT: begin
				if (sts.out_free) begin
					state_d = dmet_pkg::ST_IDLE;
				end
			end
			default: state_d = dmet_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		s_tready     = 1'b0;
		case (state_q)
			dmet_pkg::ST_SWEEP: cmd.sweep = 1'b1;
			dmet_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			dmet_pkg::ST_START: cmd.start = 1'b1;
			dmet_pkg::ST_EVAL:  cmd.eval  = 1'b1;
			dmet_pkg::ST_FIN:   cmd.fin   = 1'b1;
			dmet_pkg::ST_OUT:   cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- hdl/dmet_datapath.sv -----
// Datapath of the table core: row count and entry memories, walk
// registers, final merge and output register. Depends on dmet_pkg.
`timescale 1ns / 1ps

module dmet_datapath #(
	parameter int LOCATIONS = dmet_pkg::LOCATIONS_DEF,
	parameter int ENTRIES   = dmet_pkg::ENTRIES_DEF,
	parameter int DAYS      = dmet_pkg::DAYS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [dmet_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [dmet_pkg::M_TDATA_W-1:0]   m_tdata,
	input  dmet_pkg::dmet_cmd_t              cmd,
	output dmet_pkg::dmet_sts_t              sts
);

	localparam int RW    = $clog2(LOCATIONS);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW    = $clog2(ENTRIES + 1);
	localparam int AW    = $clog2(LOCATIONS * ENTRIES);
	localparam int TW    = dmet_pkg::TIME_W;
	localparam int EW    = TW + DAYS;
	localparam int T_LO  = dmet_pkg::LOC_W;
	localparam int D_LO  = dmet_pkg::LOC_W + dmet_pkg::TIME_W;

	logic [dmet_pkg::LOC_W-1:0] in_loc;
	logic [TW-1:0]              in_time;
	logic [DAYS-1:0]            in_days;

	logic [CW-1:0]  cnt_mem [LOCATIONS];
	logic [EW-1:0]  ent_mem [LOCATIONS * ENTRIES];

	logic [RW-1:0]    row_q, sweep_q;
	logic [AW-1:0]    base_q;
	logic [TW-1:0]    time_q;
	logic [DAYS-1:0]  days_q;
	logic [IDX_W-1:0] i_q, same_q, free_q;
	logic [DAYS-1:0]  same_days_q;
	logic             have_same_q, have_free_q;
	logic [CW-1:0]    n_q, cnt_rd_q, n_start;
	logic [EW-1:0]    ent_rd_q;
	logic [DAYS-1:0]  res_days_q;
	logic             res_ovf_q;
	logic             m_tvalid_q;
	logic [dmet_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic [TW-1:0]    ent_time;
	logic [DAYS-1:0]  ent_days, ent_days_nx, days_nx;
	logic             later, equal;
	logic [IDX_W-1:0] rd_idx, wr_idx;
	logic             ent_we, cnt_app_we, fin_write;
	logic [EW-1:0]    ent_wdata;
	logic             room;

	assign in_loc  = s_tdata[dmet_pkg::LOC_W-1:0];
	assign in_time = s_tdata[T_LO +: TW];
	assign in_days = s_tdata[D_LO +: DAYS];

	assign ent_time    = ent_rd_q[EW-1:DAYS];
	assign ent_days    = ent_rd_q[DAYS-1:0];
	assign later       = time_q < ent_time;
	assign equal       = time_q == ent_time;
	assign ent_days_nx = later ? (ent_days & ~days_q) : ent_days;
	assign days_nx     = later ? days_q : (days_q & ~ent_days);
	assign n_start     = (cnt_rd_q > CW'(ENTRIES)) ? CW'(ENTRIES) : cnt_rd_q;
	assign room        = n_q < CW'(ENTRIES);
	assign rd_idx      = cmd.eval ? (i_q + IDX_W'(1)) : i_q;
	assign fin_write   = cmd.fin && (days_q != '0) && (have_same_q || have_free_q || room);
	assign cnt_app_we  = cmd.fin && (days_q != '0) && !have_same_q && !have_free_q && room;

	always_comb begin
		ent_we    = 1'b0;
		wr_idx    = i_q;
		ent_wdata = {ent_time, ent_days_nx};
		if (cmd.eval) begin
			ent_we = later;
		end else if (fin_write) begin
			ent_we = 1'b1;
			if (have_same_q) begin
				wr_idx    = same_q;
				ent_wdata = {time_q, same_days_q | days_q};
			end else if (have_free_q) begin
				wr_idx    = free_q;
				ent_wdata = {time_q, days_q};
			end else begin
				wr_idx    = IDX_W'(n_q);
				ent_wdata = {time_q, days_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			cnt_mem[sweep_q] <= '0;
		end else if (cnt_app_we) begin
			cnt_mem[row_q] <= n_q + CW'(1);
		end
		cnt_rd_q <= cnt_mem[row_q];
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[base_q + AW'(wr_idx)] <= ent_wdata;
		end
		ent_rd_q <= ent_mem[base_q + AW'(rd_idx)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.sweep) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + RW'(1);
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			row_q       <= RW'(in_loc);
			base_q      <= AW'(RW'(in_loc)) * AW'(ENTRIES);
			time_q      <= in_time;
			days_q      <= in_days;
			i_q         <= '0;
			have_same_q <= 1'b0;
			have_free_q <= 1'b0;
			res_days_q  <= '0;
			res_ovf_q   <= 1'b0;
		end
		if (cmd.start) begin
			n_q <= n_start;
		end
		if (cmd.eval) begin
			days_q <= days_nx;
			i_q    <= i_q + IDX_W'(1);
			if (!later && equal) begin
				have_same_q <= 1'b1;
				same_q      <= i_q;
				same_days_q <= ent_days;
			end
			if (ent_days_nx == '0) begin
				have_free_q <= 1'b1;
				free_q      <= i_q;
			end
		end
		if (cmd.fin && (days_q != '0)) begin
			if (fin_write) begin
				res_days_q <= days_q;
			end else begin
				res_ovf_q <= 1'b1;
			end
		end
		if (cmd.out_load) begin
			m_tdata_q <= {7'd0, res_ovf_q, dmet_pkg::DAYS_W'(res_days_q)};
		end
	end

	always_comb begin
		sts            = '0;
		sts.sweep_last = sweep_q == RW'(LOCATIONS - 1);
		sts.clear_op   = s_tuser == dmet_pkg::OP_CLEAR;
		sts.loc_ok     = {22'd0, in_loc} < 32'(LOCATIONS);
		sts.walk_go    = (n_start != '0) && (days_q != '0);
		sts.eval_more  = (({1'b0, CW'(i_q)} + (CW + 1)'(1)) < {1'b0, n_q})
			&& (days_nx != '0);
		sts.out_free   = !m_tvalid_q || m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- hdl/day_masked_earliest_time_table_core.sv -----
// Top level of the day-masked earliest-time table core.
// Depends on dmet_pkg, dmet_ctrl and dmet_datapath.
`timescale 1ns / 1ps

// An update word walks k row entries, where k is the number of row entries walked (at most
// ENTRIES; the walk stops early once no candidate days remain); one entry is evaluated per cycle
// through the registered read port of the entry memory. Its steps are a row count read, a start
// step, the entry walk, a final write and the output load, which waits while the output register
// holds a result not yet taken. An update word with a location at or above LOCATIONS returns a
// zero result. A clear word sweeps all LOCATIONS rows of the row count memory one row a cycle,
// then returns a zero result. After reset the same sweep runs with s_tready low. A result waits
// in the output register while the next word is taken.
module day_masked_earliest_time_table_core #(
	parameter int LOCATIONS = dmet_pkg::LOCATIONS_DEF,
	parameter int ENTRIES   = dmet_pkg::ENTRIES_DEF,
	parameter int DAYS      = dmet_pkg::DAYS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// location [9:0], cand_time [30:10], days_new [94:31], zero [95]
	input  logic [dmet_pkg::S_TDATA_W-1:0] s_tdata,
	// op [0]
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// improved_days [63:0], overflow [64], zero [71:65]
	output logic [dmet_pkg::M_TDATA_W-1:0] m_tdata
);

	dmet_pkg::dmet_cmd_t cmd;
	dmet_pkg::dmet_sts_t sts;

	dmet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dmet_datapath #(
		.LOCATIONS (LOCATIONS),
		.ENTRIES   (ENTRIES),
		.DAYS      (DAYS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// ----- hdl/dmet_checker.sv -----
// Port-level checker for the table core, bound to the top level.
// Depends on dmet_pkg and day_masked_earliest_time_table_core_macros.svh.
`timescale 1ns / 1ps
`include "day_masked_earliest_time_table_core_macros.svh"

module dmet_checker #(
	parameter int DAYS = dmet_pkg::DAYS_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [dmet_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [dmet_pkg::M_TDATA_W-1:0] m_tdata
);

	`DMET_ASSERT_NXT(a_busy_after_word, clk, arst_n, s_tvalid && s_tready, !s_tready, "ready after accepted word")
	`DMET_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
	`DMET_ASSERT_IMP(a_ovf_no_days, clk, arst_n, m_tvalid && m_tdata[64], m_tdata[63:0] == 64'd0, "overflow with improved days")
	`DMET_ASSERT_IMP(a_day_range, clk, arst_n, m_tvalid, (m_tdata[71:65] == 7'd0) && ((m_tdata[63:0] >> DAYS) == 64'd0), "result bits beyond day range")

endmodule

bind day_masked_earliest_time_table_core dmet_checker #(.DAYS(DAYS)) u_dmet_checker (.*);

// ----- bench/tb_day_masked_earliest_time_table_core.sv -----
// Testbench for day_masked_earliest_time_table_core: directed and random update and
// clear words, checked word by word against a table model kept in a scoreboard class.
// Depends on dmet_pkg and the core.
`timescale 1ns / 1ps

module tb_day_masked_earliest_time_table_core;

	localparam int LOCS = dmet_pkg::LOCATIONS_DEF;
	localparam int SLOTS = dmet_pkg::ENTRIES_DEF;
	localparam logic [63:0] DAY_MASK = {64{1'b1}} >> (64 - dmet_pkg::DAYS_DEF);
	localparam logic OP_UPDATE = ~dmet_pkg::OP_CLEAR;
	localparam int QUIET_LIMIT = 6000;
	localparam int LONG_HOLD = 400;
	localparam int TAIL_CYCLES = 40;
	localparam int CHUNKS = 7;
	localparam int CHUNK_WORDS = 205;

	typedef struct packed {
		logic [63:0] improved;
		logic        overflow;
	} day_result_t;

	class day_table_board;
		int          row_used [LOCS];
		bit [20:0]   slot_time [LOCS][SLOTS];
		bit [63:0]   slot_days [LOCS][SLOTS];
		day_result_t awaited [$];
		int          errors;
		int          n_update;
		int          n_clear;
		int          n_improved;
		int          n_overflow;

		function new();
			foreach (row_used[i])
				row_used[i] = 0;
			errors = 0;
			n_update = 0;
			n_clear = 0;
			n_improved = 0;
			n_overflow = 0;
		endfunction

		function int awaited_count();
			return awaited.size();
		endfunction

		function void note_word(logic op, logic [9:0] loc, logic [20:0] t, logic [63:0] d);
			day_result_t r;
			bit [63:0]   cand;
			int          n;
			bit          have_same;
			bit          have_free;
			int          same_ix;
			int          free_ix;
			r = '0;
			cand = d & DAY_MASK;
			have_same = 1'b0;
			have_free = 1'b0;
			same_ix = 0;
			free_ix = 0;
			if (op == dmet_pkg::OP_CLEAR) begin
				foreach (row_used[i])
					row_used[i] = 0;
				n_clear++;
			end else if (loc < LOCS) begin
				n_update++;
				n = row_used[loc];
				if (n > SLOTS)
					n = SLOTS;
				for (int i = 0; i < n && cand != 0; i++) begin
					if (t < slot_time[loc][i]) begin
						slot_days[loc][i] &= ~cand;
					end else begin
						cand &= ~slot_days[loc][i];
						if (t == slot_time[loc][i]) begin
							have_same = 1'b1;
							same_ix = i;
						end
					end
					if (slot_days[loc][i] == 0) begin
						have_free = 1'b1;
						free_ix = i;
					end
				end
				if (cand != 0) begin
					if (have_same) begin
						slot_days[loc][same_ix] |= cand;
						r.improved = cand;
					end else if (have_free) begin
						slot_time[loc][free_ix] = t;
						slot_days[loc][free_ix] = cand;
						r.improved = cand;
					end else if (n < SLOTS) begin
						slot_time[loc][n] = t;
						slot_days[loc][n] = cand;
						row_used[loc] = n + 1;
						r.improved = cand;
					end else begin
						r.overflow = 1'b1;
					end
				end
				if (r.improved != 0)
					n_improved++;
				if (r.overflow)
					n_overflow++;
			end
			awaited = {awaited, r};
		endfunction

		function void check_word(logic [dmet_pkg::M_TDATA_W-1:0] data);
			day_result_t e;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $time, data);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (data[63:0] !== e.improved) begin
				$display("%0t: improved_days mismatch, expected %h, actual %h",
					$time, e.improved, data[63:0]);
				errors++;
			end
			if (data[64] !== e.overflow) begin
				$display("%0t: overflow mismatch, expected %b, actual %b",
					$time, e.overflow, data[64]);
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	// location [9:0], cand_time [30:10], days_new [94:31], zero [95]
	logic [dmet_pkg::S_TDATA_W-1:0] s_tdata;
	// op [0]
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	// improved_days [63:0], overflow [64], zero [71:65]
	logic [dmet_pkg::M_TDATA_W-1:0] m_tdata;

	day_table_board board;
	bit             steady = 1'b0;
	bit             long_hold_go = 1'b0;
	int             quiet = 0;
	int unsigned    hot_rows [6];
	logic [20:0]    time_base;

	day_masked_earliest_time_table_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_word(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, quiet);
			$display("tb_day_masked_earliest_time_table_core: errors");
			$finish;
		end
	end

	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_go) begin
				long_hold_go = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	task automatic send_word(logic op, logic [9:0] loc, logic [20:0] t, logic [63:0] d);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, d, t, loc};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_word(op, loc, t, d);
	endtask

	task automatic sender_gap();
		if (!steady && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.awaited_count() != 0)
			@(posedge clk);
	endtask

	task automatic send_checked(logic op, logic [9:0] loc, logic [20:0] t, logic [63:0] d);
		send_word(op, loc, t, d);
		sender_gap();
	endtask

	task automatic run_directed();
		send_checked(OP_UPDATE, 10'd0, 21'd100, {64{1'b1}});
		send_checked(OP_UPDATE, 10'd0, 21'd100, {64{1'b1}});
		send_checked(OP_UPDATE, 10'd0, 21'd100, 64'd0);
		send_checked(OP_UPDATE, 10'd1023, 21'h1FFFFF, 64'h8000_0000_0000_0001);
		// earlier time empties the stored entry; reuse it
		send_checked(OP_UPDATE, 10'd1023, 21'd0, {64{1'b1}});
		for (int i = 0; i < SLOTS; i++)
			send_checked(OP_UPDATE, 10'd5, 21'(10 * (i + 1)), 64'd1 << i);
		send_checked(OP_UPDATE, 10'd5, 21'd90, 64'd1 << 8);
		send_checked(OP_UPDATE, 10'd5, 21'd5, (64'd1 << 0) | (64'd1 << 9));
		send_checked(OP_UPDATE, 10'd5, 21'd20, 64'd1 << 10);
		send_checked(OP_UPDATE, 10'd5, 21'd85, 64'd1 << 11);
		// strip days from a later entry, then drop on a full row
		send_checked(OP_UPDATE, 10'd5, 21'd15, (64'd1 << 10) | (64'd1 << 13));
		send_checked(dmet_pkg::OP_CLEAR, 10'h2AA, 21'h15555, 64'hDEAD_BEEF_0123_4567);
		send_checked(OP_UPDATE, 10'd5, 21'd90, 64'd1 << 8);
		send_checked(OP_UPDATE, 10'd1023, 21'h1FFFFF, 64'd1);
	endtask

	task automatic pick_hot_rows();
		foreach (hot_rows[i])
			hot_rows[i] = $urandom_range(0, LOCS - 1);
		time_base = 21'($urandom_range(0, 21'h1FFFFF - 200));
	endtask

	task automatic send_random();
		logic        op;
		logic [9:0]  loc;
		logic [20:0] t;
		logic [63:0] d;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		op = ($urandom_range(0, 149) == 0) ? dmet_pkg::OP_CLEAR : OP_UPDATE;
		if ($urandom_range(0, 19) < 17)
			loc = 10'(hot_rows[$urandom_range(0, 5)]);
		else
			loc = 10'($urandom_range(0, LOCS - 1));
		if ($urandom_range(0, 9) == 0)
			t = 21'($urandom_range(0, 21'h1FFFFF));
		else
			t = time_base + 21'($urandom_range(0, 11) * 7);
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: d = a & b & c;
			5, 6: d = 64'd1 << $urandom_range(0, 63);
			7: d = a;
			8: d = {64{1'b1}};
			default: d = {56'd0, a[7:0]};
		endcase
		send_word(op, loc, t, d);
		sender_gap();
	endtask

	initial begin
		board = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= 1'b0;
		s_tdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		drain_results();
		for (int k = 0; k < CHUNKS; k++) begin
			pick_hot_rows();
			if (k == CHUNKS - 1)
				steady = 1'b1;
			if (k == 2) begin
				// back up the output while words keep coming
				long_hold_go = 1'b1;
				for (int j = 0; j < 20; j++)
					send_word(OP_UPDATE, 10'(hot_rows[j % 6]), time_base + 21'(j), 64'd1 << j);
			end
			for (int j = 0; j < CHUNK_WORDS; j++)
				send_random();
			if (k % 2 == 1)
				drain_results();
		end
		s_tvalid <= 1'b0;
		while (board.awaited_count() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d updates and %0d clears, %0d of them improving and %0d overflowing",
			board.n_update, board.n_clear, board.n_improved, board.n_overflow);
		$display("mismatches found: %0d", board.errors);
		if (board.errors == 0)
			$display("tb_day_masked_earliest_time_table_core: clean");
		else
			$display("tb_day_masked_earliest_time_table_core: errors");
		$finish;
	end

endmodule
